### design/mvwo_pkg.sv
// shared types, constants and the sine table builder for the waveform oscillator
// no dependencies
package mvwo_pkg;

  localparam int TRACKS_DEF          = 8;
  localparam int BLOCK_SAMPLES_DEF   = 64;
  localparam int SINE_TABLE_BITS_DEF = 10;

  localparam int QUEUE_DEPTH = 2;
  localparam int COUNT_W     = 32;
  localparam int STEP_W      = 32;
  localparam int PHASE_W     = 33;
  localparam int AMP_W       = 15;
  localparam int VOICE_W     = 3;
  localparam int SAMPLE_W    = 16;
  localparam int PROD_W      = PHASE_W + AMP_W + 1;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [2:0] {
    OP_SQUARE   = 3'd0,
    OP_SINE     = 3'd1,
    OP_TRIANGLE = 3'd2,
    OP_SAWTOOTH = 3'd3,
    OP_PULSE5   = 3'd4,
    OP_PULSE12  = 3'd5,
    OP_NOISE    = 3'd6,
    OP_SILENT   = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    SH_DIRECT,
    SH_SINE,
    SH_TRI,
    SH_SAW,
    SH_NOISE
  } shape_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_READ,
    FR_PUSH
  } front_state_t;

  typedef struct packed {
    op_t                op;
    logic               mute;
    logic [VOICE_W-1:0] voice;
    logic [AMP_W-1:0]   amp;
    logic [STEP_W-1:0]  step;
    logic [PHASE_W-1:0] phase0;
  } note_t;

  // quarter-wave sine entry in q15, taylor series to z^11 in q30
  function automatic logic [15:0] sine_entry(input int unsigned k, input int unsigned bits);
    logic [63:0]        z;
    logic [63:0]        z2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        q;
    z    = (64'(k) * HALF_PI_Q30) >> bits;
    z2   = (z * z) >> 30;
    term = z;
    sum  = $signed(z);
    term = ((term * z2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * z2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * z2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * z2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * z2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    q = ($unsigned(sum) + 64'd16384) >> 15;
    if (q > 64'd32768) begin
      q = 64'd32768;
    end
    return q[15:0];
  endfunction

endpackage

### design/mvwo_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module mvwo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/mvwo_front.sv
// front end: accepts notes, classifies them, keeps the per-track sample counters
// and computes the start phase; uses mvwo_pkg and mvwo_ram
module mvwo_front
  import mvwo_pkg::*;
#(
  parameter int TRACKS        = TRACKS_DEF,
  parameter int BLOCK_SAMPLES = BLOCK_SAMPLES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VOICE_W-1:0] track,
  input  logic [STEP_W-1:0]  phase_step,
  input  logic [AMP_W-1:0]   amplitude,
  input  logic [2:0]         timbre,
  output logic               push,
  output note_t              note,
  input  logic               full
);

  localparam int TRK_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;

  front_state_t state, state_next;

  logic               rd_en;
  logic               wr_en;
  logic [COUNT_W-1:0] rd_data;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [63:0]        start_prod;
  logic [TRACKS-1:0]  cnt_valid;
  logic [TRK_W-1:0]   trk_idx;
  logic               trk_ok;
  logic               in_trk_ok;
  op_t                in_op;

  // classification of the incoming note
  always_comb begin
    in_trk_ok = 32'(track) < 32'(TRACKS);
    in_op     = op_t'(timbre);
    if (!in_trk_ok) begin
      in_op = OP_SILENT;
    end else if (phase_step == '0 && in_op != OP_NOISE) begin
      in_op = OP_SILENT;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE: if (in_valid) state_next = FR_READ;
      FR_READ: state_next = FR_PUSH;
      FR_PUSH: if (!full) state_next = FR_IDLE;
      default: state_next = FR_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    push     = 1'b0;
    unique case (state)
      FR_IDLE: begin
        in_stall = 1'b0;
        rd_en    = in_valid;
      end
      FR_READ: wr_en = trk_ok;
      FR_PUSH: push = !full;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_valid <= '0;
    end else if (wr_en) begin
      cnt_valid[trk_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == FR_IDLE && in_valid) begin
      trk_idx    <= TRK_W'(track);
      trk_ok     <= in_trk_ok;
      note.op    <= in_op;
      note.mute  <= (phase_step == '0);
      note.voice <= track;
      note.amp   <= amplitude;
      note.step  <= phase_step;
    end
    if (state == FR_READ) begin
      note.phase0 <= start_prod[PHASE_W-1:0];
    end
  end

  // counter is zero until first written
  always_comb begin
    count      = (trk_ok && cnt_valid[trk_idx]) ? rd_data : '0;
    count_next = count + COUNT_W'(BLOCK_SAMPLES);
    start_prod = 64'(count) * 64'(note.step);
  end

  mvwo_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (TRACKS)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (trk_idx),
    .wr_data (count_next),
    .rd_en   (rd_en),
    .rd_addr (TRK_W'(track)),
    .rd_data (rd_data)
  );

`ifndef SYNTH
  a_accept_reads : assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == FR_READ))
    else $error("accepted transaction did not start a counter read");
  a_push_not_full : assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("note pushed into a full queue");
`endif

endmodule

### design/mvwo_queue.sv
// short note queue between front and back end
// uses mvwo_pkg
module mvwo_queue
  import mvwo_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  note_t push_note,
  output logic  full,
  input  logic  pop,
  output note_t head,
  output logic  empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  note_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full  = (fill == CNT_W'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_note;
    end
  end

endmodule

### design/mvwo_back.sv
// back end: phase accumulator, noise lfsr, sine rom, scaling multiplier and
// output register; uses mvwo_pkg
module mvwo_back
  import mvwo_pkg::*;
#(
  parameter int BLOCK_SAMPLES   = BLOCK_SAMPLES_DEF,
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  note_t                      head,
  input  logic                       empty,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic [VOICE_W-1:0]         voice,
  output logic                       last
);

  localparam int N_W    = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
  localparam int SINE_N = 1 << SINE_TABLE_BITS;
  localparam int ROM_AW = SINE_TABLE_BITS + 1;

  logic [15:0] sine_rom [SINE_N + 1];

  for (genvar i = 0; i < SINE_N + 1; i++) begin : g_rom
    localparam logic [15:0] ENTRY = sine_entry(i, SINE_TABLE_BITS);
    assign sine_rom[i] = ENTRY;
  end

  logic en;
  logic emit;
  logic gen_last;

  logic [N_W-1:0]     n;
  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_cur;
  logic [15:0]        lfsr;
  logic [15:0]        lfsr_next;

  logic [31:0]                f;
  logic [1:0]                 quad;
  logic [SINE_TABLE_BITS-1:0] k;
  logic [ROM_AW-1:0]          rom_addr;
  logic [36:0]                f_x20;
  logic [SAMPLE_W-1:0]        amp_s;
  logic signed [32:0]         tri_r;

  shape_t                     g_kind;
  logic signed [SAMPLE_W-1:0] g_direct;
  logic signed [PHASE_W-1:0]  g_x;

  logic                       p1_valid;
  shape_t                     p1_kind;
  logic                       p1_neg;
  logic signed [SAMPLE_W-1:0] p1_direct;
  logic signed [PHASE_W-1:0]  p1_x;
  logic [15:0]                p1_rom;
  logic [AMP_W-1:0]           p1_amp;
  logic [VOICE_W-1:0]         p1_voice;
  logic                       p1_last;

  logic signed [PHASE_W-1:0]  p1_mul;
  logic signed [PROD_W-1:0]   prod_next;

  logic                       p2_valid;
  shape_t                     p2_kind;
  logic                       p2_neg;
  logic signed [SAMPLE_W-1:0] p2_direct;
  logic signed [PROD_W-1:0]   p2_prod;
  logic [AMP_W-1:0]           p2_amp;
  logic [VOICE_W-1:0]         p2_voice;
  logic                       p2_last;

  logic signed [PROD_W-1:0]   sine_mag;
  logic signed [PROD_W-1:0]   tri_val;
  logic signed [PROD_W-1:0]   saw_val;
  logic signed [PROD_W-1:0]   noise_val;
  logic signed [PROD_W-1:0]   sel;

  assign en       = !out_valid || !out_stall;
  assign emit     = en && !empty;
  assign gen_last = (n == N_W'(BLOCK_SAMPLES - 1));
  assign pop      = emit && gen_last;

  // sample generator
  always_comb begin
    phase_cur = (n == '0) ? head.phase0 : phase;
    f         = phase_cur[31:0];
    quad      = f[31:30];
    k         = f[29 -: SINE_TABLE_BITS];
    rom_addr  = quad[0] ? (ROM_AW'(SINE_N) - ROM_AW'(k)) : ROM_AW'(k);
    lfsr_next = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? LFSR_TAPS : 16'h0000);
    f_x20     = ({5'b0, f} << 4) + ({5'b0, f} << 2);
    amp_s     = {1'b0, head.amp};
    tri_r     = {3'b000, f[29:0]};
  end

  always_comb begin
    g_kind   = SH_DIRECT;
    g_direct = '0;
    g_x      = '0;
    unique case (head.op)
      OP_SQUARE: g_direct = phase_cur[32] ? -amp_s : amp_s;
      OP_SINE:   g_kind = SH_SINE;
      OP_TRIANGLE: begin
        g_kind = SH_TRI;
        case (quad)
          2'd0:    g_x = tri_r;
          2'd1:    g_x = 33'sd1073741824 - tri_r;
          2'd2:    g_x = -tri_r;
          default: g_x = tri_r - 33'sd1073741824;
        endcase
      end
      OP_SAWTOOTH: begin
        g_kind = SH_SAW;
        g_x    = {f[31], f};
      end
      OP_PULSE5:
        g_direct = (!f[31] && f_x20 > 37'h9_0000_0000) ? amp_s : '0;
      OP_PULSE12:
        g_direct = (!f[31] && f > 32'h6000_0000) ? amp_s : '0;
      OP_NOISE: begin
        g_kind = head.mute ? SH_DIRECT : SH_NOISE;
        g_x    = {17'b0, lfsr_next};
      end
      default: g_direct = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n    <= '0;
      lfsr <= LFSR_SEED;
    end else if (emit) begin
      n <= gen_last ? '0 : n + 1'b1;
      if (head.op == OP_NOISE) begin
        lfsr <= lfsr_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      phase <= phase_cur + {1'b0, head.step};
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p1_valid  <= emit;
      p2_valid  <= p1_valid;
      out_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_kind   <= g_kind;
      p1_neg    <= quad[1];
      p1_direct <= g_direct;
      p1_x      <= g_x;
      p1_rom    <= sine_rom[rom_addr];
      p1_amp    <= head.amp;
      p1_voice  <= head.voice;
      p1_last   <= gen_last;
    end
  end

  // scaling multiply
  always_comb begin
    p1_mul    = (p1_kind == SH_SINE) ? $signed({17'b0, p1_rom}) : p1_x;
    prod_next = p1_mul * $signed({1'b0, p1_amp});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_kind   <= p1_kind;
      p2_neg    <= p1_neg;
      p2_direct <= p1_direct;
      p2_prod   <= prod_next;
      p2_amp    <= p1_amp;
      p2_voice  <= p1_voice;
      p2_last   <= p1_last;
    end
  end

  // rounding and final select
  always_comb begin
    sine_mag  = (p2_prod + 49'sd16384) >>> 15;
    tri_val   = (p2_prod + 49'sd536870912) >>> 30;
    saw_val   = (p2_prod + 49'sd1073741824) >>> 31;
    noise_val = (p2_prod >>> 15) - $signed({34'b0, p2_amp});
    unique case (p2_kind)
      SH_SINE:  sel = p2_neg ? -sine_mag : sine_mag;
      SH_TRI:   sel = tri_val;
      SH_SAW:   sel = saw_val;
      SH_NOISE: sel = noise_val;
      default:  sel = {{(PROD_W - SAMPLE_W){p2_direct[SAMPLE_W-1]}}, p2_direct};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sample <= sel[SAMPLE_W-1:0];
      voice  <= p2_voice;
      last   <= p2_last;
    end
  end

`ifndef SYNTH
  a_lfsr_nonzero : assert property (@(posedge clk) disable iff (rst)
    lfsr != '0)
    else $error("noise lfsr reached the all-zero state");
  a_pop_restarts : assert property (@(posedge clk) disable iff (rst)
    pop |=> (n == '0))
    else $error("sample index not restarted after a note finished");
`endif

endmodule

### design/multi_voice_waveform_oscillator.sv
// path: front end read and push states, note queue, back end p1, p2 and output
// registers; throughput: one sample per cycle unless the queue is empty or the
// output stalls; the front end stalls its input until a note is pushed (counter ram)
// reset: counters read as zero through per-track valid bits, lfsr seeded, no
// clearing pass
module multi_voice_waveform_oscillator
  import mvwo_pkg::*;
#(
  parameter int TRACKS          = TRACKS_DEF,
  parameter int BLOCK_SAMPLES   = BLOCK_SAMPLES_DEF,
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [VOICE_W-1:0]         track,
  input  logic [STEP_W-1:0]          phase_step,
  input  logic [AMP_W-1:0]           amplitude,
  input  logic [2:0]                 timbre,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic [VOICE_W-1:0]         voice,
  output logic                       last
);

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  note_t q_in;
  note_t q_head;

  mvwo_front #(
    .TRACKS        (TRACKS),
    .BLOCK_SAMPLES (BLOCK_SAMPLES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .track      (track),
    .phase_step (phase_step),
    .amplitude  (amplitude),
    .timbre     (timbre),
    .push       (q_push),
    .note       (q_in),
    .full       (q_full)
  );

  mvwo_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_note (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  mvwo_back #(
    .BLOCK_SAMPLES   (BLOCK_SAMPLES),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample),
    .voice     (voice),
    .last      (last)
  );

endmodule

### verif/multi_voice_waveform_oscillator_test.sv
// self-checking testbench for multi_voice_waveform_oscillator: notes in, 64 samples out each
// predicts every sample from its own per-track counters, noise lfsr and quarter-wave table
// depends on mvwo_pkg and the design top level only
`timescale 1ns / 100ps

module multi_voice_waveform_oscillator_test
  import mvwo_pkg::*;
();

  localparam int NOTE_SAMPLES = 64;
  localparam int VOICES = 8;
  localparam int TABLE_BITS = 10;
  localparam int TABLE_SIZE = 1 << TABLE_BITS;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [VOICE_W-1:0] track;
    logic [STEP_W-1:0]  step;
    logic [AMP_W-1:0]   amp;
    op_t                op;
    bit                 drain;
  } note_req_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic [VOICE_W-1:0]         voice;
    logic                       last;
  } sample_exp_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [VOICE_W-1:0]         track = '0;
  logic [STEP_W-1:0]          phase_step = '0;
  logic [AMP_W-1:0]           amplitude = '0;
  logic [2:0]                 timbre = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;
  logic [VOICE_W-1:0]         voice;
  logic                       last;

  note_req_t   pending_notes[$];
  sample_exp_t expected_samples[$];
  note_req_t   next_note;

  logic [31:0] voice_count [VOICES];
  logic [15:0] noise_reg = 16'hACE1;
  logic [15:0] quarter_sine [0:TABLE_SIZE];

  bit note_taken = 1'b0;
  bit calm = 1'b0;
  bit want_hold = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int mismatches = 0;
  int cycles = 0;

  multi_voice_waveform_oscillator i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .track      (track),
    .phase_step (phase_step),
    .amplitude  (amplitude),
    .timbre     (timbre),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample     (sample),
    .voice      (voice),
    .last       (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [15:0] quarter_sine_q15(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned pwr;
    longint          acc;
    longint unsigned r;
    x   = (longint'(k) * QUARTER_TURN_Q30) >> TABLE_BITS;
    x2  = (x * x) >> 30;
    pwr = x;
    acc = longint'(x);
    for (int n = 1; n <= 9; n += 2) begin
      pwr = ((pwr * x2) >> 30) / longint'((n + 1) * (n + 2));
      if (((n + 1) / 2) % 2 == 1) begin
        acc = acc - longint'(pwr);
      end else begin
        acc = acc + longint'(pwr);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    r = (longint'(acc) + 16384) >> 15;
    if (r > 32768) begin
      r = 32768;
    end
    return r[15:0];
  endfunction

  // round(a * v / 2^sh) with |v| <= 2^sh
  function automatic longint round_scaled(input longint a, input longint v, input int sh);
    longint acc;
    acc = a * v + (a <<< sh) + (longint'(1) <<< (sh - 1));
    return (acc >>> sh) - a;
  endfunction

  task automatic synth_note(input logic [VOICE_W-1:0] t, input logic [STEP_W-1:0] step,
                            input logic [AMP_W-1:0] amp, input op_t op);
    logic [63:0]  ph;
    logic [31:0]  f;
    logic [1:0]   quad;
    logic [TABLE_BITS-1:0] k;
    longint       a;
    longint       v;
    longint       mag;
    longint       r;
    sample_exp_t  e;
    a = longint'(amp);
    for (int n = 0; n < NOTE_SAMPLES; n++) begin
      ph   = 64'(voice_count[t]) * 64'(step);
      f    = ph[31:0];
      quad = f[31:30];
      v    = 0;
      case (op)
        OP_NOISE: begin
          noise_reg = noise_reg[0] ? ((noise_reg >> 1) ^ 16'hB400) : (noise_reg >> 1);
          v = ((longint'(noise_reg) * 2 * a) >>> 16) - a;
        end
        OP_SQUARE: v = ph[32] ? -a : a;
        OP_SINE: begin
          k   = f[29:30-TABLE_BITS];
          mag = round_scaled(a, longint'(quad[0] ? quarter_sine[TABLE_SIZE - k]
                                                 : quarter_sine[k]), 15);
          v   = quad[1] ? -mag : mag;
        end
        OP_TRIANGLE: begin
          r = longint'(f[29:0]);
          case (quad)
            2'd0: v = round_scaled(a, r, 30);
            2'd1: v = round_scaled(a, (longint'(1) <<< 30) - r, 30);
            2'd2: v = round_scaled(a, -r, 30);
            default: v = round_scaled(a, r - (longint'(1) <<< 30), 30);
          endcase
        end
        OP_SAWTOOTH: v = round_scaled(a, longint'($signed(f)), 31);
        OP_PULSE5: v = (!f[31] && (64'(f) * 64'd20 > (64'd9 << 32))) ? a : 0;
        OP_PULSE12: v = (!f[31] && f > 32'h6000_0000) ? a : 0;
        default: v = 0;
      endcase
      if (step == '0) begin
        v = 0;
      end
      voice_count[t] = voice_count[t] + 32'd1;
      e.value = v[15:0];
      e.voice = t;
      e.last  = (n == NOTE_SAMPLES - 1);
      expected_samples.push_back(e);
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("mismatch on %0s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
  endtask

  // sender, inputs change on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !note_taken) begin
      in_valid <= 1'b1;
    end else if (pending_notes.size() != 0 &&
                 (!pending_notes[0].drain || expected_samples.size() == 0) &&
                 (calm || $urandom_range(99) >= 12)) begin
      next_note   = pending_notes.pop_front();
      in_valid   <= 1'b1;
      track      <= next_note.track;
      phase_step <= next_note.step;
      amplitude  <= next_note.amp;
      timbre     <= next_note.op;
    end else begin
      in_valid <= 1'b0;
    end
    note_taken = 1'b0;
  end

  // receiver stall, including one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (want_hold && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 12);
    end
  end

  // prediction and checking, sampled on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        synth_note(track, phase_step, amplitude, op_t'(timbre));
        note_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("unexpected sample", sample, 0);
        end else begin
          if (sample !== expected_samples[0].value) begin
            report_mismatch("sample", sample, expected_samples[0].value);
          end
          if (voice !== expected_samples[0].voice) begin
            report_mismatch("voice", voice, expected_samples[0].voice);
          end
          if (last !== expected_samples[0].last) begin
            report_mismatch("last", last, expected_samples[0].last);
          end
          void'(expected_samples.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("multi_voice_waveform_oscillator regression: fail");
      $finish;
    end
  end

  task automatic push_note(input int t, input logic [31:0] step, input int amp, input op_t op,
                           input bit drain);
    note_req_t req;
    req.track = t[VOICE_W-1:0];
    req.step  = step;
    req.amp   = amp[AMP_W-1:0];
    req.op    = op;
    req.drain = drain;
    pending_notes.push_back(req);
  endtask

  task automatic push_random_notes(input int count, input bit drain_first);
    logic [31:0] step;
    int          amp;
    int          sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(9);
      case (sel)
        0: step = '0;
        1, 2: step = $urandom();
        3, 4, 5, 6: step = $urandom_range(32'h0800_0000);
        7: step = 32'h0400_0000 >> $urandom_range(8);
        8: step = $urandom_range(255);
        default: step = 32'hFFFF_FFFF - $urandom_range(255);
      endcase
      sel = $urandom_range(9);
      amp = (sel == 0) ? 0 : (sel == 1) ? 32767 : $urandom_range(32767);
      push_note($urandom_range(VOICES - 1), step, amp, op_t'($urandom_range(7)),
                drain_first && i == 0);
    end
  endtask

  task automatic wait_notes_sent();
    while (pending_notes.size() != 0 || in_valid) begin
      @(posedge clk);
    end
  endtask

  initial begin
    for (int k = 0; k <= TABLE_SIZE; k++) begin
      quarter_sine[k] = quarter_sine_q15(k);
    end
    for (int t = 0; t < VOICES; t++) begin
      voice_count[t] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every timbre over one full turn of the 32-bit phase at full scale
    push_note(0, 32'h0400_0000, 32767, OP_SQUARE, 1'b0);
    push_note(1, 32'h0400_0000, 32767, OP_SINE, 1'b0);
    push_note(2, 32'h0400_0000, 32767, OP_TRIANGLE, 1'b0);
    push_note(3, 32'h0400_0000, 32767, OP_SAWTOOTH, 1'b0);
    push_note(4, 32'h0400_0000, 32767, OP_PULSE5, 1'b0);
    push_note(5, 32'h0400_0000, 32767, OP_PULSE12, 1'b0);
    push_note(6, 32'h0400_0000, 32767, OP_NOISE, 1'b0);
    push_note(7, 32'h0400_0000, 32767, OP_SILENT, 1'b0);
    // zero step, counter and noise still advance
    push_note(0, 32'h0000_0000, 32767, OP_SQUARE, 1'b0);
    push_note(6, 32'h0000_0000, 32767, OP_NOISE, 1'b0);
    push_note(2, 32'h0000_0000, 32767, OP_SAWTOOTH, 1'b0);
    // zero and unit amplitude
    push_note(1, 32'h1234_5678, 0, OP_SINE, 1'b0);
    push_note(6, 32'h0400_0000, 0, OP_NOISE, 1'b0);
    push_note(3, 32'h0200_0000, 1, OP_TRIANGLE, 1'b0);
    push_note(3, 32'h0200_0000, 1, OP_SINE, 1'b0);
    // extreme steps
    push_note(7, 32'hFFFF_FFFF, 32767, OP_SAWTOOTH, 1'b0);
    push_note(7, 32'hFFFF_FFFF, 32767, OP_SQUARE, 1'b0);
    push_note(5, 32'h8000_0000, 32767, OP_SQUARE, 1'b0);
    push_note(5, 32'h8000_0000, 32767, OP_TRIANGLE, 1'b0);
    push_note(4, 32'h0000_0001, 32767, OP_SINE, 1'b0);
    // fine steps around the pulse edges and through the triangle corners
    push_note(0, 32'h0100_0000, 32767, OP_PULSE5, 1'b0);
    push_note(1, 32'h0100_0000, 21845, OP_PULSE12, 1'b0);
    push_note(2, 32'h0080_0000, 32767, OP_TRIANGLE, 1'b0);
    wait_notes_sent();

    // long receiver hold while notes keep coming
    push_random_notes(120, 1'b0);
    want_hold = 1'b1;
    wait_notes_sent();

    // no idling on either side, starting from an empty pipe
    calm = 1'b1;
    push_random_notes(100, 1'b1);
    wait_notes_sent();
    calm = 1'b0;

    push_random_notes(130, 1'b1);
    wait_notes_sent();

    while (expected_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("multi_voice_waveform_oscillator regression: pass");
    end else begin
      $display("multi_voice_waveform_oscillator regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
design/mvwo_pkg.sv
design/mvwo_ram.sv
design/mvwo_front.sv
design/mvwo_queue.sv
design/mvwo_back.sv
design/multi_voice_waveform_oscillator.sv
verif/multi_voice_waveform_oscillator_test.sv
